[design/stereo_biquad_cascade_macros.svh]
// Assertion macros for the stereo biquad cascade.
// Used by stereo_biquad_cascade.sv; expects clk_i and rst_ni in scope.
`ifndef STEREO_BIQUAD_CASCADE_MACROS_SVH
`define STEREO_BIQUAD_CASCADE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SBQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SBQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sbq_pkg.sv]
// Shared types and constants of the stereo biquad cascade.
// No dependencies; imported by sbq_lane and stereo_biquad_cascade.
package sbq_pkg;

  localparam int COEF_BITS       = 32;
  localparam int NUM_COEFS       = 5;
  localparam int HIST_GUARD_BITS = 16;
  localparam int SECTION_W       = 4;
  localparam int SLOT_W          = 3;
  localparam int COUNT_W         = 5;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_FILTER = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  typedef enum logic [1:0] {
    OPND_V1,
    OPND_V2,
    OPND_W
  } opnd_e;

  typedef enum logic {
    ACC_SEL_W,
    ACC_SEL_Y
  } acc_e;

  // Per-cycle control from the section sequencer to each channel lane.
  typedef struct packed {
    logic  issue;     // start a coefficient x operand product
    opnd_e opnd;
    acc_e  tgt;       // accumulator the product lands in
    logic  neg;       // subtract instead of add
    logic  init;      // acc_w = x << frac, acc_y = 0
    logic  cap_hist;  // take v1/v2 from history memory output
    logic  rnd_w;     // round/saturate acc_w into w
    logic  rnd_y;     // round/saturate acc_y into x (next section input)
    logic  load_x;    // take new input sample
  } lane_ctrl_t;

endpackage

[design/sbq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; holds coefficient and history storage.
module sbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sbq_lane.sv]
// One channel datapath of the biquad cascade: split multiplier, accumulators,
// rounding and saturation. Depends on sbq_pkg.
module sbq_lane import sbq_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28,
  localparam int HIST_BITS = SAMPLE_BITS + HIST_GUARD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctrl_t                    ctrl_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [HIST_BITS-1:0]   hist_v1_i,
  input  logic signed [HIST_BITS-1:0]   hist_v2_i,
  output logic signed [HIST_BITS-1:0]   w_o,
  output logic signed [HIST_BITS-1:0]   v1_o,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  // Operand split into a signed upper half and an unsigned lower half so
  // each partial product stays near 32x20.
  localparam int LO_W     = HIST_BITS / 2;
  localparam int HI_W     = HIST_BITS - LO_W;
  localparam int PLO_W    = COEF_BITS + LO_W + 1;
  localparam int PHI_W    = COEF_BITS + HI_W;
  localparam int PROD_W   = COEF_BITS + HIST_BITS;
  localparam int ACC_BITS = PROD_W + 3;
  localparam int SH_W     = ACC_BITS - COEF_FRAC_BITS;

  localparam logic signed [ACC_BITS-1:0] HALF =
    {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
  localparam logic signed [SH_W-1:0] H_MAX =
    {{(SH_W-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
  localparam logic signed [SH_W-1:0] H_MIN = ~H_MAX;
  localparam logic signed [SH_W-1:0] S_MAX =
    {{(SH_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SH_W-1:0] S_MIN = ~S_MAX;

  logic signed [HIST_BITS-1:0]   v1_q, v2_q, w_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [HIST_BITS-1:0]   opnd;
  logic signed [PLO_W-1:0]       pp_lo_d, pp_lo_q;
  logic signed [PHI_W-1:0]       pp_hi_d, pp_hi_q;
  logic signed [PROD_W-1:0]      prod_d, prod_q;
  logic signed [ACC_BITS-1:0]    acc_w_q, acc_y_q;
  logic signed [ACC_BITS-1:0]    rnd_src, rnd_sum;
  logic signed [SH_W-1:0]        sh;
  logic signed [HIST_BITS-1:0]   w_sat;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  logic s1_vld_q, s1_neg_q, s2_vld_q, s2_neg_q;
  acc_e s1_tgt_q, s2_tgt_q;

  always_comb begin
    case (ctrl_i.opnd)
      OPND_V1: opnd = v1_q;
      OPND_V2: opnd = v2_q;
      OPND_W:  opnd = w_q;
      default: opnd = v1_q;
    endcase
  end

  assign pp_lo_d = PLO_W'(coef_i) * PLO_W'($signed({1'b0, opnd[LO_W-1:0]}));
  assign pp_hi_d = PHI_W'(coef_i) * PHI_W'($signed(opnd[HIST_BITS-1:LO_W]));
  assign prod_d  = (PROD_W'(pp_hi_q) <<< LO_W) + PROD_W'(pp_lo_q);

  // Round half up, then saturate to history or sample range.
  assign rnd_src = ctrl_i.rnd_y ? acc_y_q : acc_w_q;
  assign rnd_sum = rnd_src + HALF;
  assign sh      = $signed(rnd_sum[ACC_BITS-1:COEF_FRAC_BITS]);

  always_comb begin
    if (sh > H_MAX) begin
      w_sat = H_MAX[HIST_BITS-1:0];
    end else if (sh < H_MIN) begin
      w_sat = H_MIN[HIST_BITS-1:0];
    end else begin
      w_sat = sh[HIST_BITS-1:0];
    end
    if (sh > S_MAX) begin
      y_sat = S_MAX[SAMPLE_BITS-1:0];
    end else if (sh < S_MIN) begin
      y_sat = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = sh[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_neg_q <= 1'b0;
      s1_tgt_q <= ACC_SEL_W;
      s2_vld_q <= 1'b0;
      s2_neg_q <= 1'b0;
      s2_tgt_q <= ACC_SEL_W;
    end else begin
      s1_vld_q <= ctrl_i.issue;
      s1_neg_q <= ctrl_i.neg;
      s1_tgt_q <= ctrl_i.tgt;
      s2_vld_q <= s1_vld_q;
      s2_neg_q <= s1_neg_q;
      s2_tgt_q <= s1_tgt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    prod_q  <= prod_d;
    if (ctrl_i.cap_hist) begin
      v1_q <= hist_v1_i;
      v2_q <= hist_v2_i;
    end
    if (ctrl_i.load_x) begin
      x_q <= sample_i;
    end else if (ctrl_i.rnd_y) begin
      x_q <= y_sat;
    end
    if (ctrl_i.rnd_w) begin
      w_q <= w_sat;
    end
    if (ctrl_i.init) begin
      acc_w_q <= ACC_BITS'(x_q) <<< COEF_FRAC_BITS;
      acc_y_q <= '0;
    end else if (s2_vld_q) begin
      if (s2_tgt_q == ACC_SEL_W) begin
        acc_w_q <= s2_neg_q ? acc_w_q - ACC_BITS'(prod_q) : acc_w_q + ACC_BITS'(prod_q);
      end else begin
        acc_y_q <= s2_neg_q ? acc_y_q - ACC_BITS'(prod_q) : acc_y_q + ACC_BITS'(prod_q);
      end
    end
  end

  assign w_o  = w_q;
  assign v1_o = v1_q;
  assign y_o  = x_q;

endmodule

[design/stereo_biquad_cascade.sv]
// Stereo cascade of direct form II biquad sections, fixed point.
// Depends on sbq_pkg, sbq_ram, sbq_lane and stereo_biquad_cascade_macros.svh.
//
// Input channel (in_valid_i/in_ready_o) carries two kinds of transaction:
//   load   - writes one Q4.28 coefficient of one section and zeroes that
//            section's history in both channels; yields no result.
//   filter - runs a Q1.23 left/right pair through sections 0..N-1, where N is
//            section_count capped at MAX_SECTIONS, and yields one result.
// Output channel (out_valid_o/out_ready_i) carries the saturated pair.
// A filter transaction goes from acceptance through N section passes to the
// done state, which loads the output register and raises out_valid_o; the
// next transaction is taken only after that. Each section is an 11-step
// schedule around one coefficient memory read port and one split multiplier
// per channel; the block works on one transaction at a time.
// The output register parts the two sides: a new transaction is taken while
// a result waits; a finished filter waits in the done state until the
// previous result is taken.
// After reset a clearing pass zeroes every address of both memories, with
// in_ready_o low; cfg_we_i writes are taken at any time.
module stereo_biquad_cascade import sbq_pkg::*; #(
  parameter int MAX_SECTIONS   = 16,
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [COUNT_W-1:0]            cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [SECTION_W-1:0]          section_i,
  input  logic [SLOT_W-1:0]             coef_slot_i,
  input  logic signed [COEF_BITS-1:0]   coef_value_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_left_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_right_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] out_left_o,
  output logic signed [SAMPLE_BITS-1:0] out_right_o
);

`include "stereo_biquad_cascade_macros.svh"

  localparam int HIST_BITS = SAMPLE_BITS + HIST_GUARD_BITS;
  localparam int ROW_W     = 4 * HIST_BITS;
  localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W     = $clog2(MAX_SECTIONS + 1);
  localparam int CDEPTH    = MAX_SECTIONS * NUM_COEFS;
  localparam int CA_W      = $clog2(CDEPTH);

  // Section schedule steps.
  localparam logic [3:0] STEP_HIST_RD = 4'd0;
  localparam logic [3:0] STEP_CAP     = 4'd1;
  localparam logic [3:0] STEP_A1      = 4'd2;
  localparam logic [3:0] STEP_A2      = 4'd3;
  localparam logic [3:0] STEP_B1      = 4'd4;
  localparam logic [3:0] STEP_B2      = 4'd5;
  localparam logic [3:0] STEP_RND_W   = 4'd6;
  localparam logic [3:0] STEP_HIST_WR = 4'd7;
  localparam logic [3:0] STEP_LAST    = 4'd10;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [CA_W-1:0]         clr_q;
  logic [SEC_W-1:0]        sec_q;
  logic [3:0]              step_q;
  logic [COUNT_W-1:0]      count_q;
  logic                    out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_left_q, out_right_q;

  logic [CNT_W-1:0]        n_eff;
  logic                    sec_last;
  logic                    load_ok;
  lane_ctrl_t              ctrl;
  logic [SLOT_W-1:0]       rd_slot;

  logic                    coef_we, coef_re;
  logic [CA_W-1:0]         coef_waddr, coef_raddr;
  logic [COEF_BITS-1:0]    coef_wdata, coef_rdata;
  logic                    hist_we, hist_re;
  logic [SEC_W-1:0]        hist_waddr;
  logic [ROW_W-1:0]        hist_wdata, hist_rdata;

  logic signed [HIST_BITS-1:0]   l_w, l_v1, r_w, r_v1;
  logic signed [SAMPLE_BITS-1:0] l_y, r_y;

  always_comb begin
    if (32'(count_q) > MAX_SECTIONS) begin
      n_eff = CNT_W'(MAX_SECTIONS);
    end else begin
      n_eff = CNT_W'(count_q);
    end
  end

  assign sec_last = (CNT_W'(sec_q) + CNT_W'(1)) == n_eff;
  assign load_ok  = (32'(section_i) < MAX_SECTIONS) && (32'(coef_slot_i) < NUM_COEFS);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

  assign coef_raddr = CA_W'(sec_q) * CA_W'(NUM_COEFS) + CA_W'(rd_slot);

  // Sequencer decode: memory accesses and lane control per step.
  always_comb begin
    ctrl       = '0;
    rd_slot    = SLOT_B0;
    coef_we    = 1'b0;
    coef_waddr = '0;
    coef_wdata = '0;
    coef_re    = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = '0;
    hist_wdata = '0;
    hist_re    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        coef_we    = 1'b1;
        coef_waddr = clr_q;
        if (32'(clr_q) < MAX_SECTIONS) begin
          hist_we    = 1'b1;
          hist_waddr = SEC_W'(clr_q);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_LOAD) begin
            if (load_ok) begin
              coef_we    = 1'b1;
              coef_waddr = CA_W'(section_i) * CA_W'(NUM_COEFS) + CA_W'(coef_slot_i);
              coef_wdata = coef_value_i;
              hist_we    = 1'b1;
              hist_waddr = SEC_W'(section_i);
            end
          end else begin
            ctrl.load_x = 1'b1;
          end
        end
      end
      ST_RUN: begin
        case (step_q)
          STEP_HIST_RD: begin
            hist_re = 1'b1;
          end
          STEP_CAP: begin
            ctrl.cap_hist = 1'b1;
            coef_re       = 1'b1;
            rd_slot       = SLOT_A1;
          end
          STEP_A1: begin
            ctrl.init  = 1'b1;
            ctrl.issue = 1'b1;
            ctrl.opnd  = OPND_V1;
            ctrl.tgt   = ACC_SEL_W;
            ctrl.neg   = 1'b1;
            coef_re    = 1'b1;
            rd_slot    = SLOT_A2;
          end
          STEP_A2: begin
            ctrl.issue = 1'b1;
            ctrl.opnd  = OPND_V2;
            ctrl.tgt   = ACC_SEL_W;
            ctrl.neg   = 1'b1;
            coef_re    = 1'b1;
            rd_slot    = SLOT_B1;
          end
          STEP_B1: begin
            ctrl.issue = 1'b1;
            ctrl.opnd  = OPND_V1;
            ctrl.tgt   = ACC_SEL_Y;
            coef_re    = 1'b1;
            rd_slot    = SLOT_B2;
          end
          STEP_B2: begin
            ctrl.issue = 1'b1;
            ctrl.opnd  = OPND_V2;
            ctrl.tgt   = ACC_SEL_Y;
          end
          STEP_RND_W: begin
            ctrl.rnd_w = 1'b1;
            coef_re    = 1'b1;
            rd_slot    = SLOT_B0;
          end
          STEP_HIST_WR: begin
            ctrl.issue = 1'b1;
            ctrl.opnd  = OPND_W;
            ctrl.tgt   = ACC_SEL_Y;
            hist_we    = 1'b1;
            hist_waddr = sec_q;
            // new v1 = w, new v2 = old v1
            hist_wdata = {r_v1, r_w, l_v1, l_w};
          end
          STEP_LAST: begin
            ctrl.rnd_y = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      sec_q       <= '0;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_left_q  <= '0;
      out_right_q <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (clr_q == CA_W'(CDEPTH - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_q <= clr_q + CA_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid_i && (cmd_i == CMD_FILTER)) begin
            sec_q   <= '0;
            step_q  <= '0;
            state_q <= (n_eff == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_q == STEP_LAST) begin
            step_q <= '0;
            if (sec_last) begin
              state_q <= ST_DONE;
            end else begin
              sec_q <= sec_q + SEC_W'(1);
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_left_q  <= l_y;
            out_right_q <= r_y;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  sbq_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (CDEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_wdata),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  sbq_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SECTIONS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (sec_q),
    .rdata_o (hist_rdata)
  );

  sbq_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .coef_i    ($signed(coef_rdata)),
    .sample_i  (sample_left_i),
    .hist_v1_i ($signed(hist_rdata[HIST_BITS-1:0])),
    .hist_v2_i ($signed(hist_rdata[2*HIST_BITS-1:HIST_BITS])),
    .w_o       (l_w),
    .v1_o      (l_v1),
    .y_o       (l_y)
  );

  sbq_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_lane_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .coef_i    ($signed(coef_rdata)),
    .sample_i  (sample_right_i),
    .hist_v1_i ($signed(hist_rdata[3*HIST_BITS-1:2*HIST_BITS])),
    .hist_v2_i ($signed(hist_rdata[4*HIST_BITS-1:3*HIST_BITS])),
    .w_o       (r_w),
    .v1_o      (r_v1),
    .y_o       (r_y)
  );

  `SBQ_ASSERT_IMP(a_coef_wr_when_quiet, coef_we, (state_q == ST_IDLE) || (state_q == ST_CLEAR), "coefficient write during filtering")
  `SBQ_ASSERT_IMP(a_hist_wr_step, hist_we && (state_q == ST_RUN), step_q == STEP_HIST_WR, "history write-back at wrong step")
  `SBQ_ASSERT_IMP(a_step_range, state_q == ST_RUN, step_q <= STEP_LAST, "section step out of range")
  `SBQ_ASSERT_NXT(a_done_waits, (state_q == ST_DONE) && out_valid_q && !out_ready_i, state_q == ST_DONE, "result overwritten while stalled")

endmodule
